// ----- hw/rtl/bgi_pkg.sv -----
// Package for the bilinear grid interpolator: item types, operation codes,
// grid size constants and the controller state type. Depends on nothing.
package bgi_pkg;

    localparam int GridPoints = 16;
    localparam int IdxW       = $clog2(GridPoints);
    localparam int GridDepth  = GridPoints * GridPoints;
    localparam int GridAw     = $clog2(GridDepth);

    typedef enum logic [1:0] {
        OP_LOAD_X = 2'd0,
        OP_LOAD_Y = 2'd1,
        OP_LOAD_Z = 2'd2,
        OP_QUERY  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_W   = 2'd1,
        ST_SATURATE = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]         operation;
        logic [3:0]         x_index;
        logic [3:0]         y_index;
        logic signed [31:0] load_value;
        logic signed [31:0] query_x;
        logic signed [31:0] query_y;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] interpolated;
        logic [1:0]         status;
    } t_out_item;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_EDGE_RD0,
        S_EDGE_RD1,
        S_EDGE_CAP,
        S_DIV_INIT,
        S_DIV_RUN,
        S_DIV_FIX,
        S_Z_RD,
        S_Z_CAP,
        S_MUL_SETUP,
        S_MUL_RUN,
        S_MUL_DONE,
        S_SAT,
        S_OUT
    } t_state;

endpackage

// ----- hw/rtl/bilinear_grid_interpolator_core.sv -----
// Top level of the bilinear grid interpolator: axis and grid memories,
// a query sequencer, a serial divider and a serial scaled multiplier.
// Depends on bgi_pkg.
//
// Usage: items enter on i_in_valid / o_in_stall carrying bgi_pkg::t_in_item.
// Load items (operations 0..2) write one axis or grid entry in the cycle they
// are accepted and give no result; the 4-bit indices always lie within the
// grid, so no load is dropped. A query item gives one bgi_pkg::t_out_item on
// o_out_valid / i_out_stall.
// Steps of a query: cell search (up to four read/compare steps, both axes in
// step, through registered axis memory reads), cell edge reads, two serial
// divisions, four grid memory reads, three shift-add multiplies and a
// saturation step; most of the work lies in the serial divider and multiplier.
// One query is in work at a time; o_in_stall is high while the sequencer is
// out of idle, from after acceptance of a query until its result has been
// taken and the sequencer has returned to idle, so a new query is accepted only
// after the last result has been taken. Loads are accepted one per cycle while
// idle.
// Reset clears the sequencer and the output valid; the memories are not
// cleared and must be written before they are read.
// When the receiver stalls, the result holds steady and no new item enters.
module bilinear_grid_interpolator_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  bgi_pkg::t_in_item    i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output bgi_pkg::t_out_item   o_out_item
);

    localparam int IW = bgi_pkg::IdxW;

    // Memories.
    logic signed [31:0] r_xmem [bgi_pkg::GridPoints];
    logic signed [31:0] r_ymem [bgi_pkg::GridPoints];
    logic signed [31:0] r_zmem [bgi_pkg::GridDepth];
    logic signed [31:0] r_xrd, r_yrd, r_zrd;
    logic [IW-1:0]      n_xaddr, n_yaddr;
    logic [bgi_pkg::GridAw-1:0] n_zaddr;

    bgi_pkg::t_state r_state, n_state;

    logic signed [31:0] r_qx, r_qy;
    logic [IW:0] r_xlo, r_xhi, r_ylo, r_yhi;
    logic [IW:0] xmid, ymid;
    logic signed [32:0] r_x0, r_y0, r_wx, r_wy, r_ox, r_oy;
    logic        r_zw;
    logic        r_axis;       // 0: working on x, 1: on y
    logic [1:0]  r_zsel;
    logic signed [31:0] r_z00, r_z10, r_z01, r_z11;

    // Divider.
    logic [49:0] r_dq;
    logic [49:0] r_drem;
    logic [32:0] r_dden;
    logic [49:0] r_dnum;
    logic [5:0]  r_cnt;
    logic        r_dneg;
    logic signed [49:0] r_t, r_u;

    // Multiplier (magnitudes 64 x 64 serial shift-add, 128-bit product).
    logic [63:0]  r_ma, r_mb;
    logic [127:0] r_mp;
    logic         r_mneg;
    logic [1:0]   r_mstep;
    logic signed [63:0] r_a, r_b, r_z;

    logic        r_out_valid;
    bgi_pkg::t_out_item r_out;

    logic accept_in;
    logic load_ok;
    assign o_in_stall  = (r_state != bgi_pkg::S_IDLE);
    assign accept_in   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign xmid = (r_xlo + r_xhi) >> 1;
    assign ymid = (r_ylo + r_yhi) >> 1;
    assign load_ok = 1'b1;

    // Memory write and read ports.
    always_ff @(posedge i_clk) begin
        if (accept_in && load_ok) begin
            unique case (bgi_pkg::t_op'(i_in_item.operation))
                bgi_pkg::OP_LOAD_X: r_xmem[i_in_item.x_index[IW-1:0]] <= i_in_item.load_value;
                bgi_pkg::OP_LOAD_Y: r_ymem[i_in_item.x_index[IW-1:0]] <= i_in_item.load_value;
                bgi_pkg::OP_LOAD_Z: r_zmem[{i_in_item.y_index[IW-1:0],
                                            i_in_item.x_index[IW-1:0]}] <= i_in_item.load_value;
                bgi_pkg::OP_QUERY: ;
                default: ;
            endcase
        end
        r_xrd <= r_xmem[n_xaddr];
        r_yrd <= r_ymem[n_yaddr];
        r_zrd <= r_zmem[n_zaddr];
    end

    // Multiplier operands: a = fraction, b = value difference.
    logic signed [63:0] mul_a, mul_b;
    always_comb begin
        unique case (r_mstep)
            2'd0: begin mul_a = 64'(r_t); mul_b = 64'(r_z10) - 64'(r_z00); end
            2'd1: begin mul_a = 64'(r_t); mul_b = 64'(r_z11) - 64'(r_z01); end
            default: begin mul_a = 64'(r_u); mul_b = r_b - r_a; end
        endcase
    end

    // Scaled product result: trunc(|a*b|/65536) clamped to 2^60, signed.
    logic [63:0] sp_mag;
    logic signed [63:0] sp_val;
    always_comb begin
        if (r_mp[127:76] != '0) sp_mag = 64'(1) << 60;
        else                   sp_mag = r_mp[79:16];
        if (sp_mag > (64'(1) << 60)) sp_mag = 64'(1) << 60;
        sp_val = r_mneg ? -$signed(sp_mag) : $signed(sp_mag);
    end

    // Divider step.
    logic [50:0] drem_sh;
    logic [50:0] dtrial;
    assign drem_sh = {r_drem, r_dnum[49]};
    assign dtrial  = drem_sh - 51'(r_dden);

    // Address selection.
    always_comb begin
        n_xaddr = xmid[IW-1:0];
        n_yaddr = ymid[IW-1:0];
        n_zaddr = '0;
        if (r_state == bgi_pkg::S_EDGE_RD0 || r_state == bgi_pkg::S_EDGE_RD1) begin
            n_xaddr = (r_state == bgi_pkg::S_EDGE_RD0) ? r_xlo[IW-1:0] : r_xhi[IW-1:0];
            n_yaddr = (r_state == bgi_pkg::S_EDGE_RD0) ? r_ylo[IW-1:0] : r_yhi[IW-1:0];
        end
        unique case (r_zsel)
            2'd0: n_zaddr = {r_ylo[IW-1:0], r_xlo[IW-1:0]};
            2'd1: n_zaddr = {r_ylo[IW-1:0], r_xhi[IW-1:0]};
            2'd2: n_zaddr = {r_yhi[IW-1:0], r_xlo[IW-1:0]};
            default: n_zaddr = {r_yhi[IW-1:0], r_xhi[IW-1:0]};
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bgi_pkg::S_IDLE:
                if (accept_in && i_in_item.operation == bgi_pkg::OP_QUERY)
                    n_state = bgi_pkg::S_SRCH_RD;
            bgi_pkg::S_SRCH_RD:  n_state = bgi_pkg::S_SRCH_CMP;
            bgi_pkg::S_SRCH_CMP: n_state = bgi_pkg::S_SRCH_RD;
            bgi_pkg::S_EDGE_RD0: n_state = bgi_pkg::S_EDGE_RD1;
            bgi_pkg::S_EDGE_RD1: n_state = bgi_pkg::S_EDGE_CAP;
            bgi_pkg::S_EDGE_CAP: n_state = bgi_pkg::S_DIV_INIT;
            bgi_pkg::S_DIV_INIT: n_state = bgi_pkg::S_DIV_RUN;
            bgi_pkg::S_DIV_RUN:  if (r_cnt == 6'd49) n_state = bgi_pkg::S_DIV_FIX;
            bgi_pkg::S_DIV_FIX:  n_state = r_axis ? bgi_pkg::S_Z_RD : bgi_pkg::S_DIV_INIT;
            bgi_pkg::S_Z_RD:     n_state = bgi_pkg::S_Z_CAP;
            bgi_pkg::S_Z_CAP:    n_state = (r_zsel == 2'd3) ? bgi_pkg::S_MUL_SETUP
                                                            : bgi_pkg::S_Z_RD;
            bgi_pkg::S_MUL_SETUP: n_state = bgi_pkg::S_MUL_RUN;
            bgi_pkg::S_MUL_RUN:  if (r_cnt == 6'd63) n_state = bgi_pkg::S_MUL_DONE;
            bgi_pkg::S_MUL_DONE: n_state = (r_mstep == 2'd2) ? bgi_pkg::S_SAT
                                                             : bgi_pkg::S_MUL_SETUP;
            bgi_pkg::S_SAT:      n_state = bgi_pkg::S_OUT;
            bgi_pkg::S_OUT:      if (!r_out_valid) n_state = bgi_pkg::S_IDLE;
            default:             n_state = bgi_pkg::S_IDLE;
        endcase
        if (r_state == bgi_pkg::S_SRCH_RD && r_xhi <= r_xlo + 1 && r_yhi <= r_ylo + 1)
            n_state = bgi_pkg::S_EDGE_RD0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= bgi_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            if (r_state == bgi_pkg::S_SAT) r_out_valid <= 1'b1;
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            bgi_pkg::S_IDLE: begin
                r_qx   <= i_in_item.query_x;
                r_qy   <= i_in_item.query_y;
                r_xlo  <= '0;
                r_ylo  <= '0;
                r_xhi  <= (IW+1)'(bgi_pkg::GridPoints - 1);
                r_yhi  <= (IW+1)'(bgi_pkg::GridPoints - 1);
                r_zw   <= 1'b0;
                r_axis <= 1'b0;
                r_zsel <= 2'd0;
                r_mstep <= 2'd0;
            end
            bgi_pkg::S_SRCH_CMP: begin
                if (r_xhi > r_xlo + 1) begin
                    if (r_xrd > r_qx) r_xhi <= xmid;
                    else              r_xlo <= xmid;
                end
                if (r_yhi > r_ylo + 1) begin
                    if (r_yrd > r_qy) r_yhi <= ymid;
                    else              r_ylo <= ymid;
                end
            end
            bgi_pkg::S_EDGE_RD0: begin
                r_xhi <= r_xlo + (IW+1)'(1);
                r_yhi <= r_ylo + (IW+1)'(1);
            end
            bgi_pkg::S_EDGE_RD1: begin
                r_x0 <= 33'(r_xrd);
                r_y0 <= 33'(r_yrd);
                r_ox <= 33'(r_qx) - 33'(r_xrd);
                r_oy <= 33'(r_qy) - 33'(r_yrd);
            end
            bgi_pkg::S_EDGE_CAP: begin
                r_wx <= 33'(r_xrd) - r_x0;
                r_wy <= 33'(r_yrd) - r_y0;
            end
            bgi_pkg::S_DIV_INIT: begin
                logic signed [32:0] off, wid;
                off = r_axis ? r_oy : r_ox;
                wid = r_axis ? r_wy : r_wx;
                r_dnum <= 50'(off[32] ? -off : off) << 16;
                r_dden <= wid[32] ? 33'(-wid) : 33'(wid);
                r_dneg <= off[32] ^ wid[32];
                r_drem <= '0;
                r_dq   <= '0;
                r_cnt  <= '0;
                if (wid == '0) r_zw <= 1'b1;
            end
            bgi_pkg::S_DIV_RUN: begin
                r_cnt  <= r_cnt + 6'd1;
                r_dnum <= r_dnum << 1;
                if (!dtrial[50]) begin
                    r_drem <= dtrial[49:0];
                    r_dq   <= {r_dq[48:0], 1'b1};
                end else begin
                    r_drem <= drem_sh[49:0];
                    r_dq   <= {r_dq[48:0], 1'b0};
                end
            end
            bgi_pkg::S_DIV_FIX: begin
                logic signed [49:0] f;
                f = (r_dden == '0) ? '0 : (r_dneg ? -$signed(r_dq) : $signed(r_dq));
                if (r_axis) r_u <= f;
                else        r_t <= f;
                r_axis <= 1'b1;
            end
            bgi_pkg::S_Z_CAP: begin
                unique case (r_zsel)
                    2'd0: r_z00 <= r_zrd;
                    2'd1: r_z10 <= r_zrd;
                    2'd2: r_z01 <= r_zrd;
                    default: r_z11 <= r_zrd;
                endcase
                r_zsel <= r_zsel + 2'd1;
            end
            bgi_pkg::S_MUL_SETUP: begin
                r_ma   <= mul_a[63] ? 64'(-mul_a) : 64'(mul_a);
                r_mb   <= mul_b[63] ? 64'(-mul_b) : 64'(mul_b);
                r_mneg <= mul_a[63] ^ mul_b[63];
                r_mp   <= '0;
                r_cnt  <= '0;
            end
            bgi_pkg::S_MUL_RUN: begin
                r_cnt <= r_cnt + 6'd1;
                r_ma  <= r_ma >> 1;
                if (r_ma[0]) r_mp <= r_mp + ({64'd0, r_mb} << r_cnt);
            end
            bgi_pkg::S_MUL_DONE: begin
                unique case (r_mstep)
                    2'd0: r_a <= 64'(r_z00) + sp_val;
                    2'd1: r_b <= 64'(r_z01) + sp_val;
                    default: r_z <= r_a + sp_val;
                endcase
                r_mstep <= r_mstep + 2'd1;
            end
            bgi_pkg::S_SAT: begin
                if (r_z > 64'sd2147483647) begin
                    r_out.interpolated <= 32'h7FFF_FFFF;
                    r_out.status <= r_zw ? bgi_pkg::ST_ZERO_W : bgi_pkg::ST_SATURATE;
                end else if (r_z < -64'sd2147483648) begin
                    r_out.interpolated <= 32'h8000_0000;
                    r_out.status <= r_zw ? bgi_pkg::ST_ZERO_W : bgi_pkg::ST_SATURATE;
                end else begin
                    r_out.interpolated <= r_z[31:0];
                    r_out.status <= r_zw ? bgi_pkg::ST_ZERO_W : bgi_pkg::ST_OK;
                end
            end
            default: ;
        endcase
    end

    // Assertions.
    a_out_only_after_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == bgi_pkg::S_SAT))
        else $error("result raised outside saturation step");
    a_stall_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> o_in_stall)
        else $error("input open while result pending");
    a_search_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == bgi_pkg::S_SRCH_CMP |-> (r_xlo < r_xhi) && (r_ylo < r_yhi))
        else $error("search bounds crossed");
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.status != 2'd3)
        else $error("bad status code");

endmodule

// ----- tb/sv/tb_bilinear_grid_interpolator_core.sv -----
// Self-checking testbench for bilinear_grid_interpolator_core: a directed table
// followed by random load and query traffic, checked against table results or an in-bench predictor.
// Depends on bgi_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_bilinear_grid_interpolator_core;

    localparam longint ProdLimit = 64'sd1 << 60;
    localparam logic signed [31:0] SMax = 32'sh7fffffff;
    localparam logic signed [31:0] SMin = 32'sh80000000;
    localparam int One = 65536;

    typedef struct {
        bgi_pkg::t_in_item  item;
        bit                 typed;
        bgi_pkg::t_out_item result;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    bgi_pkg::t_in_item  i_in_item = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    bgi_pkg::t_out_item o_out_item;

    bilinear_grid_interpolator_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #1 i_clk = ~i_clk;

    t_row      stim[$];
    bgi_pkg::t_out_item pending_points[$];
    logic signed [31:0] px_axis [bgi_pkg::GridPoints];
    logic signed [31:0] py_axis [bgi_pkg::GridPoints];
    logic signed [31:0] pz_grid [bgi_pkg::GridDepth];
    logic signed [31:0] gen_x [bgi_pkg::GridPoints];
    logic signed [31:0] gen_y [bgi_pkg::GridPoints];
    int  n_accepted = 0;
    int  n_loads = 0;
    int  n_queries = 0;
    int  n_checked = 0;
    int  n_errors = 0;
    bit  calm = 1'b0;

    function automatic int unsigned find_cell(bit on_y, logic signed [31:0] q);
        int unsigned lo, hi, mid;
        logic signed [31:0] v;
        lo = 0;
        hi = bgi_pkg::GridPoints - 1;
        while (hi > lo + 1) begin
            mid = (lo + hi) / 2;
            v = on_y ? py_axis[mid] : px_axis[mid];
            if (v > q) hi = mid;
            else lo = mid;
        end
        return lo;
    endfunction

    function automatic longint cell_frac(bit on_y, int unsigned i, logic signed [31:0] q,
                                         ref bit zero_w);
        longint w, off;
        if (on_y) begin
            w = longint'(py_axis[i + 1]) - longint'(py_axis[i]);
            off = longint'(q) - longint'(py_axis[i]);
        end else begin
            w = longint'(px_axis[i + 1]) - longint'(px_axis[i]);
            off = longint'(q) - longint'(px_axis[i]);
        end
        if (w == 0) begin
            zero_w = 1'b1;
            return 0;
        end
        return (off * One) / w;
    endfunction

    // trunc(a*b/65536), clamped to +-2^60.
    function automatic longint scaled_mul(longint a, longint b);
        logic signed [127:0] p;
        logic [127:0] m;
        longint q;
        p = a;
        p = p * b;
        m = (p < 0) ? -p : p;
        m = m >> 16;
        if (m > ProdLimit) m = ProdLimit;
        q = longint'(m);
        return (p < 0) ? -q : q;
    endfunction

    function automatic bgi_pkg::t_out_item blend_point(logic signed [31:0] qx,
                                                       logic signed [31:0] qy);
        int unsigned xi, yi;
        bit zero_w;
        longint t, u, z00, z10, z01, z11, a, b, z;
        bgi_pkg::t_out_item r;
        zero_w = 1'b0;
        xi = find_cell(1'b0, qx);
        yi = find_cell(1'b1, qy);
        t = cell_frac(1'b0, xi, qx, zero_w);
        u = cell_frac(1'b1, yi, qy, zero_w);
        z00 = pz_grid[yi * bgi_pkg::GridPoints + xi];
        z10 = pz_grid[yi * bgi_pkg::GridPoints + xi + 1];
        z01 = pz_grid[(yi + 1) * bgi_pkg::GridPoints + xi];
        z11 = pz_grid[(yi + 1) * bgi_pkg::GridPoints + xi + 1];
        a = z00 + scaled_mul(t, z10 - z00);
        b = z01 + scaled_mul(t, z11 - z01);
        z = a + scaled_mul(u, b - a);
        r.status = zero_w ? bgi_pkg::ST_ZERO_W : bgi_pkg::ST_OK;
        if (z > longint'(SMax)) begin
            z = SMax;
            if (!zero_w) r.status = bgi_pkg::ST_SATURATE;
        end else if (z < longint'(SMin)) begin
            z = SMin;
            if (!zero_w) r.status = bgi_pkg::ST_SATURATE;
        end
        r.interpolated = z[31:0];
        return r;
    endfunction

    task automatic add_item(bgi_pkg::t_op op, int xi, int yi, logic signed [31:0] val,
                            logic signed [31:0] qx, logic signed [31:0] qy,
                            bit typed = 1'b0, bgi_pkg::t_out_item res = '0);
        t_row r;
        r.item.operation = op;
        r.item.x_index = xi[3:0];
        r.item.y_index = yi[3:0];
        r.item.load_value = val;
        r.item.query_x = qx;
        r.item.query_y = qy;
        r.typed = typed;
        r.result = res;
        stim.push_back(r);
        if (op == bgi_pkg::OP_LOAD_X) gen_x[xi[3:0]] = val;
        if (op == bgi_pkg::OP_LOAD_Y) gen_y[xi[3:0]] = val;
    endtask

    // A full sorted axis with random spacing; some cells have zero width.
    task automatic add_axis(bgi_pkg::t_op op);
        logic signed [31:0] c;
        c = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
        for (int i = 0; i < bgi_pkg::GridPoints; i++) begin
            add_item(op, i, $urandom, c, $urandom, $urandom);
            if ($urandom_range(0, 9) != 0) c = c + $urandom_range(1, 4 * One);
        end
    endtask

    function automatic logic signed [31:0] near_axis(bit on_y);
        logic signed [31:0] lo, hi;
        lo = on_y ? gen_y[0] : gen_x[0];
        hi = on_y ? gen_y[bgi_pkg::GridPoints - 1] : gen_x[bgi_pkg::GridPoints - 1];
        if (hi < lo) return $urandom;
        return lo - 2 * One + $signed($urandom_range(0, hi - lo + 4 * One));
    endfunction

    task automatic build_stimulus();
        bgi_pkg::t_out_item r;
        int pick;
        // Plain unit grid, all zero values, so that every entry is written first.
        for (int i = 0; i < bgi_pkg::GridPoints; i++) begin
            add_item(bgi_pkg::OP_LOAD_X, i, $urandom, i * One, $urandom, $urandom);
            add_item(bgi_pkg::OP_LOAD_Y, i, $urandom, i * One, $urandom, $urandom);
        end
        for (int i = 0; i < bgi_pkg::GridDepth; i++)
            add_item(bgi_pkg::OP_LOAD_Z, i % bgi_pkg::GridPoints, i / bgi_pkg::GridPoints,
                     0, $urandom, $urandom);

        // Directed table.
        r = '{interpolated: 0, status: bgi_pkg::ST_OK};
        add_item(bgi_pkg::OP_QUERY, 0, 0, 0, 0, 0, 1'b1, r);
        add_item(bgi_pkg::OP_LOAD_Z, 0, 0, SMax, 0, 0);
        add_item(bgi_pkg::OP_LOAD_Z, 1, 0, SMin, 0, 0);
        r = '{interpolated: SMax, status: bgi_pkg::ST_OK};
        add_item(bgi_pkg::OP_QUERY, 15, 15, SMin, 0, 0, 1'b1, r);
        r = '{interpolated: SMin, status: bgi_pkg::ST_OK};
        add_item(bgi_pkg::OP_QUERY, 0, 0, 0, One, 0, 1'b1, r);
        // Extrapolation below the first cell runs into the upper rail; a point
        // further along falls in a cell of zero values.
        r = '{interpolated: SMax, status: bgi_pkg::ST_SATURATE};
        add_item(bgi_pkg::OP_QUERY, 0, 0, 0, -One, 0, 1'b1, r);
        r = '{interpolated: 0, status: bgi_pkg::ST_OK};
        add_item(bgi_pkg::OP_QUERY, 0, 0, 0, 3 * One, 0, 1'b1, r);
        // Collapse the last x cell to zero width.
        add_item(bgi_pkg::OP_LOAD_X, 15, 0, 14 * One, 0, 0);
        r = '{interpolated: 0, status: bgi_pkg::ST_ZERO_W};
        add_item(bgi_pkg::OP_QUERY, 0, 0, 0, 20 * One, 0, 1'b1, r);
        add_item(bgi_pkg::OP_LOAD_X, 15, 0, 15 * One, 0, 0);
        add_item(bgi_pkg::OP_QUERY, 0, 0, 0, SMin, SMin);
        add_item(bgi_pkg::OP_QUERY, 15, 15, SMax, SMax, SMax);
        add_item(bgi_pkg::OP_QUERY, 0, 0, 0, SMin, SMax);
        add_item(bgi_pkg::OP_LOAD_Z, 15, 15, SMin, 0, 0);
        add_item(bgi_pkg::OP_LOAD_Z, 14, 15, SMax, 0, 0);
        add_item(bgi_pkg::OP_QUERY, 0, 0, 0, 15 * One + One / 2, 15 * One + One / 2);
        // An unsorted x axis entry.
        add_item(bgi_pkg::OP_LOAD_X, 7, 0, SMax, 0, 0);
        add_item(bgi_pkg::OP_QUERY, 0, 0, 0, 7 * One + One / 2, 3 * One);
        add_item(bgi_pkg::OP_LOAD_X, 7, 0, 7 * One, 0, 0);
        add_item(bgi_pkg::OP_QUERY, 0, 0, 0, SMax, SMin);

        while (stim.size() < 1200) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                add_axis(bgi_pkg::OP_LOAD_X);
            end else if (pick < 12) begin
                add_axis(bgi_pkg::OP_LOAD_Y);
            end else if (pick < 40) begin
                repeat ($urandom_range(1, 8)) begin
                    add_item(bgi_pkg::OP_LOAD_Z, $urandom, $urandom,
                             ($urandom_range(0, 3) == 0) ? $urandom
                                 : $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000,
                             $urandom, $urandom);
                end
            end else if (pick < 44) begin
                // Noise: a single axis entry out of order.
                add_item($urandom_range(0, 1) ? bgi_pkg::OP_LOAD_X : bgi_pkg::OP_LOAD_Y,
                         $urandom, $urandom, $urandom, $urandom, $urandom);
            end else if (pick < 88) begin
                add_item(bgi_pkg::OP_QUERY, $urandom, $urandom, $urandom,
                         near_axis(1'b0), near_axis(1'b1));
            end else begin
                add_item(bgi_pkg::OP_QUERY, $urandom, $urandom, $urandom, $urandom,
                         $urandom);
            end
        end
    endtask

    // Prediction at acceptance and checking of results.
    always @(posedge i_clk) begin
        t_row r;
        bgi_pkg::t_out_item want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                r = stim[n_accepted];
                n_accepted++;
                case (bgi_pkg::t_op'(r.item.operation))
                    bgi_pkg::OP_LOAD_X: px_axis[r.item.x_index] = r.item.load_value;
                    bgi_pkg::OP_LOAD_Y: py_axis[r.item.x_index] = r.item.load_value;
                    bgi_pkg::OP_LOAD_Z:
                        pz_grid[r.item.y_index * bgi_pkg::GridPoints + r.item.x_index] =
                            r.item.load_value;
                    default: begin
                        want = blend_point(r.item.query_x, r.item.query_y);
                        pending_points.push_back(r.typed ? r.result : want);
                    end
                endcase
                if (bgi_pkg::t_op'(r.item.operation) == bgi_pkg::OP_QUERY) n_queries++;
                else n_loads++;
            end
            if (o_out_valid && !i_out_stall) begin
                if (pending_points.size() == 0) begin
                    $display("%0t: unexpected result %h/%0d", $time,
                             o_out_item.interpolated, o_out_item.status);
                    n_errors++;
                end else begin
                    want = pending_points.pop_front();
                    n_checked++;
                    if (o_out_item.interpolated !== want.interpolated) begin
                        $display("%0t: interpolated expected %h actual %h", $time,
                                 want.interpolated, o_out_item.interpolated);
                        n_errors++;
                    end
                    if (o_out_item.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, o_out_item.status);
                        n_errors++;
                    end
                end
            end
        end
    end

    // Result side: random stalls, plus one long hold once traffic is flowing.
    initial begin
        int n;
        bit held;
        held = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (!held && n_checked >= 100) begin
                held = 1'b1;
                n = 1500;
            end else begin
                n = calm ? 0 : $urandom_range(0, 10);
            end
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
        end
    end

    initial begin
        int gap;
        build_stimulus();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int k = 0; k < stim.size(); k++) begin
            calm = ((k / 150) % 3) == 2;
            gap = calm ? 0 : $urandom_range(0, 10);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_in_valid <= 1'b1;
            i_in_item <= stim[k].item;
            do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        end
        i_in_valid <= 1'b0;
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        $display("Covered %0d loads and %0d queries; %0d results checked.",
                 n_loads, n_queries, n_checked);
        $display("Included rails, zero-width cells, unsorted axes and a long output hold.");
        if (n_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("Timeout after %0d accepted items.", n_accepted);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
